// ----- sv/fixed_block_pool_allocator_macros.svh -----
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_macros
// Assertion macros shared by the checker of the block pool allocator.
// ----------------------------------------------------------------------------
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_MACROS_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_MACROS_SVH

// Same-cycle implication, masked while reset is held.
`define FBPA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("fbpa check failed");

// Next-cycle implication, masked while reset is held.
`define FBPA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("fbpa check failed");

`endif

// ----- sv/fbpa_pkg.sv -----
// ----------------------------------------------------------------------------
// fbpa_pkg
// Constants and shared types of the fixed block pool allocator.
// ----------------------------------------------------------------------------
package fbpa_pkg;

    localparam int NUM_POOLS       = 4;
    localparam int BLOCKS_PER_POOL = 64;
    localparam int PW = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
    localparam int BW = $clog2(BLOCKS_PER_POOL);
    localparam int CW = $clog2(2 * BLOCKS_PER_POOL);
    localparam int AW = PW + BW;
    localparam int MW = (NUM_POOLS > 1) ? $clog2(NUM_POOLS + 1) : 1;

    // Field widths of the stream items.
    localparam int FUNC_W   = 1;
    localparam int PIDX_W   = 2;
    localparam int BIDX_W   = 6;
    localparam int STATUS_W = 2;
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 16;

    localparam logic [FUNC_W-1:0] FUNC_ALLOC = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OOM      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNMAPPED = 2'd2;

    // Outcome of the evaluation cycle.
    typedef enum logic [1:0] {
        EV_DONE = 2'd0,
        EV_MAP  = 2'd1,
        EV_POP  = 2'd2
    } eval_kind_t;

    typedef struct packed {
        logic load_req;
        logic eval;
        logic init_step;
        logic pop;
        logic out_load;
    } fbpa_cmd_t;

    typedef struct packed {
        eval_kind_t kind;
        logic       init_last;
    } fbpa_sts_t;

endpackage

// ----- sv/fbpa_ctrl.sv -----
// ----------------------------------------------------------------------------
// fbpa_ctrl
// Sequencer of the allocator: accepts an item, steps the datapath, and holds
// the result channel's valid flag.
// ----------------------------------------------------------------------------
module fbpa_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    output fbpa_pkg::fbpa_cmd_t cmd,
    input  fbpa_pkg::fbpa_sts_t sts
);
    import fbpa_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EVAL = 5'b00010,
        S_INIT = 5'b00100,
        S_POP  = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        cmd           = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_req = 1'b1;
                    state_next   = S_EVAL;
                end
            end
            S_EVAL: begin
                cmd.eval = 1'b1;
                case (sts.kind)
                    EV_MAP:  state_next = S_INIT;
                    EV_POP:  state_next = S_POP;
                    default: state_next = S_DONE;
                endcase
            end
            S_INIT: begin
                cmd.init_step = 1'b1;
                if (sts.init_last) begin
                    state_next = S_POP;
                end
            end
            S_POP: begin
                cmd.pop    = 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    cmd.out_load  = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

// ----- sv/fbpa_dp.sv -----
// ----------------------------------------------------------------------------
// fbpa_dp
// Pool state, link memory and result registers of the allocator.
// ----------------------------------------------------------------------------
module fbpa_dp (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic [fbpa_pkg::S_DATA_W-1:0]        s_tdata,
    output logic [fbpa_pkg::M_DATA_W-1:0]        m_tdata,
    input  fbpa_pkg::fbpa_cmd_t                  cmd,
    output fbpa_pkg::fbpa_sts_t                  sts
);
    import fbpa_pkg::*;

    // Latched request.
    logic              func_reg;
    logic [PIDX_W-1:0] pidx_reg;
    logic [BIDX_W-1:0] bidx_reg;

    // Pool bookkeeping.
    logic [NUM_POOLS-1:0] mapped_reg, mapped_next;
    logic [CW-1:0] count_reg [NUM_POOLS];
    logic [CW-1:0] count_next [NUM_POOLS];
    logic [BW-1:0] head_reg [NUM_POOLS];
    logic [BW-1:0] head_next [NUM_POOLS];
    logic [PW-1:0] order_reg [NUM_POOLS];
    logic [PW-1:0] order_next [NUM_POOLS];
    logic [MW-1:0] mcount_reg, mcount_next;
    logic [PW-1:0] cache_reg, cache_next, spare_reg, spare_next;
    logic          cache_v_reg, cache_v_next, spare_v_reg, spare_v_next;

    logic [PW-1:0] sel_reg, sel_next;
    logic [BW-1:0] init_reg;
    logic [STATUS_W-1:0] res_st_reg, res_st_next;
    logic [PW-1:0] res_p_reg, res_p_next;
    logic [BW-1:0] res_b_reg, res_b_next;
    logic [M_DATA_W-1:0] m_tdata_reg;

    // Link memory.
    logic [BW-1:0] link_mem [NUM_POOLS*BLOCKS_PER_POOL];
    logic          wr_en, rd_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [BW-1:0] wr_data, rd_data_reg;

    // Evaluation helpers.
    logic          srch_hit, free_hit, free_ok, full_now;
    logic [PW-1:0] srch_p, free_p, alloc_p, fp, rel_pos;
    logic [BW-1:0] fb;
    logic [CW-1:0] cnt_inc, cnt_dec;
    logic          alloc_hit;
    eval_kind_t    kind;

    assign fp = pidx_reg[PW-1:0];
    assign fb = bidx_reg[BW-1:0];
    assign free_ok = (32'(pidx_reg) < NUM_POOLS) && mapped_reg[fp];

    // Newest-first search for a pool with free blocks, lowest unmapped slot.
    always_comb begin
        srch_hit = 1'b0;
        srch_p   = '0;
        free_hit = 1'b0;
        free_p   = '0;
        rel_pos  = '0;
        for (int i = NUM_POOLS - 1; i >= 0; i--) begin
            if ((32'(i) < 32'(mcount_reg)) && (count_reg[order_reg[i]] != '0)) begin
                srch_hit = 1'b1;
                srch_p   = order_reg[i];
            end
            if (!mapped_reg[i]) begin
                free_hit = 1'b1;
                free_p   = PW'(i);
            end
            if ((32'(i) < 32'(mcount_reg)) && (order_reg[i] == fp)) begin
                rel_pos = PW'(i);
            end
        end
    end

    always_comb begin
        if (cache_v_reg) begin
            alloc_hit = 1'b1;
            alloc_p   = cache_reg;
        end else if (spare_v_reg) begin
            alloc_hit = 1'b1;
            alloc_p   = spare_reg;
        end else begin
            alloc_hit = srch_hit;
            alloc_p   = srch_p;
        end
    end

    assign cnt_inc  = (count_reg[fp] < CW'(2 * BLOCKS_PER_POOL - 1)) ?
                      count_reg[fp] + 1'b1 : count_reg[fp];
    assign full_now = (cnt_inc == CW'(BLOCKS_PER_POOL));
    assign cnt_dec  = count_reg[sel_reg] - 1'b1;

    always_comb begin
        if (func_reg == FUNC_FREE) begin
            kind = EV_DONE;
        end else if (alloc_hit) begin
            kind = (count_reg[alloc_p] == '0) ? EV_DONE : EV_POP;
        end else if (free_hit) begin
            kind = EV_MAP;
        end else begin
            kind = EV_DONE;
        end
    end

    assign sts.kind      = kind;
    assign sts.init_last = (init_reg == BW'(BLOCKS_PER_POOL - 1));

    // State update for evaluate, link initialization and pop.
    always_comb begin
        mapped_next  = mapped_reg;
        count_next   = count_reg;
        head_next    = head_reg;
        order_next   = order_reg;
        mcount_next  = mcount_reg;
        cache_next   = cache_reg;
        cache_v_next = cache_v_reg;
        spare_next   = spare_reg;
        spare_v_next = spare_v_reg;
        sel_next     = sel_reg;
        res_st_next  = res_st_reg;
        res_p_next   = res_p_reg;
        res_b_next   = res_b_reg;
        wr_en        = 1'b0;
        wr_addr      = {fp, fb};
        wr_data      = head_reg[fp];
        rd_en        = 1'b0;
        rd_addr      = {alloc_p, head_reg[alloc_p]};

        if (cmd.eval) begin
            res_st_next = ST_OK;
            res_p_next  = '0;
            res_b_next  = '0;
            if (func_reg == FUNC_FREE) begin
                if (!free_ok) begin
                    res_st_next = ST_UNMAPPED;
                end else begin
                    wr_en         = 1'b1;
                    head_next[fp] = fb;
                    count_next[fp] = cnt_inc;
                    if (full_now) begin
                        if (spare_v_reg && (spare_reg != fp)) begin
                            // Release: drop it from the order list.
                            for (int i = 0; i < NUM_POOLS - 1; i++) begin
                                if (PW'(i) >= rel_pos) begin
                                    order_next[i] = order_reg[i+1];
                                end
                            end
                            mcount_next    = mcount_reg - 1'b1;
                            mapped_next[fp] = 1'b0;
                            count_next[fp]  = '0;
                            if (cache_v_reg && (cache_reg == fp)) begin
                                cache_v_next = 1'b0;
                            end
                        end else begin
                            spare_next   = fp;
                            spare_v_next = 1'b1;
                            cache_next   = fp;
                            cache_v_next = 1'b1;
                        end
                    end
                end
            end else begin
                case (kind)
                    EV_POP: begin
                        sel_next = alloc_p;
                        rd_en    = 1'b1;
                    end
                    EV_MAP: begin
                        sel_next             = free_p;
                        head_next[free_p]    = '0;
                        count_next[free_p]   = CW'(BLOCKS_PER_POOL);
                        mapped_next[free_p]  = 1'b1;
                        for (int i = 1; i < NUM_POOLS; i++) begin
                            order_next[i] = order_reg[i-1];
                        end
                        order_next[0] = free_p;
                        mcount_next   = mcount_reg + 1'b1;
                        spare_next    = free_p;
                        spare_v_next  = 1'b1;
                        cache_next    = free_p;
                        cache_v_next  = 1'b1;
                    end
                    default: res_st_next = ST_OOM;
                endcase
            end
        end

        if (cmd.init_step) begin
            wr_en   = 1'b1;
            wr_addr = {sel_reg, init_reg};
            wr_data = init_reg + 1'b1;
            if (sts.init_last) begin
                rd_en   = 1'b1;
                rd_addr = {sel_reg, head_reg[sel_reg]};
            end
        end

        if (cmd.pop) begin
            head_next[sel_reg]  = rd_data_reg;
            count_next[sel_reg] = cnt_dec;
            res_st_next         = ST_OK;
            res_p_next          = sel_reg;
            res_b_next          = head_reg[sel_reg];
            if (spare_v_reg && (spare_reg == sel_reg)) begin
                spare_v_next = 1'b0;
            end
            if (cnt_dec != '0) begin
                cache_next   = sel_reg;
                cache_v_next = 1'b1;
            end else begin
                cache_next   = spare_reg;
                cache_v_next = spare_v_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            link_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= link_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mapped_reg  <= '0;
            mcount_reg  <= '0;
            cache_v_reg <= 1'b0;
            spare_v_reg <= 1'b0;
            for (int i = 0; i < NUM_POOLS; i++) begin
                count_reg[i] <= '0;
            end
        end else begin
            mapped_reg  <= mapped_next;
            mcount_reg  <= mcount_next;
            cache_v_reg <= cache_v_next;
            spare_v_reg <= spare_v_next;
            count_reg   <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        head_reg   <= head_next;
        order_reg  <= order_next;
        cache_reg  <= cache_next;
        spare_reg  <= spare_next;
        sel_reg    <= sel_next;
        res_st_reg <= res_st_next;
        res_p_reg  <= res_p_next;
        res_b_reg  <= res_b_next;
        if (cmd.eval) begin
            init_reg <= '0;
        end else if (cmd.init_step) begin
            init_reg <= init_reg + 1'b1;
        end
        if (cmd.load_req) begin
            func_reg <= s_tdata[0];
            pidx_reg <= s_tdata[2:1];
            bidx_reg <= s_tdata[8:3];
        end
        if (cmd.out_load) begin
            m_tdata_reg <= M_DATA_W'({BIDX_W'(res_b_reg), PIDX_W'(res_p_reg), res_st_reg});
        end
    end

    assign m_tdata = m_tdata_reg;

endmodule

// ----- sv/fixed_block_pool_allocator.sv -----
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator
// Allocator of fixed-size blocks kept in pools with LIFO free lists.
// ----------------------------------------------------------------------------
//  Channel | Dir | Item contents (lowest bit first)
//  s_      | in  | func[0], pool_index[2:1], block_index[8:3]
//  m_      | out | status[1:0], granted_pool[3:2], granted_block[9:4]
//
// One item is worked on at a time. A free goes from evaluation straight to the
// result; an allocate from a mapped pool also passes a pop state, which waits
// on the registered read of the link memory. An allocate that maps a new pool
// first runs the link initialization sweep over all 64 blocks of the pool.
// Reset is synchronous and active low; it clears the pool map, counts and
// the cache and spare flags. A stalled result is held in the output register.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [fbpa_pkg::S_DATA_W-1:0]     s_tdata,  // func, pool_index, block_index
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [fbpa_pkg::M_DATA_W-1:0]     m_tdata   // status, granted_pool, granted_block
);
    import fbpa_pkg::*;

    // Commands from the sequencer, and the evaluation outcome back to it.
    fbpa_cmd_t cmd;
    fbpa_sts_t sts;

    // The sequencer owns the handshakes and steps through evaluate, link
    // initialization and pop.
    fbpa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    // The datapath holds all pool state, the link memory and the result.
    fbpa_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .m_tdata (m_tdata),
        .cmd     (cmd),
        .sts     (sts)
    );

endmodule

// ----- sv/fbpa_checker.sv -----
// ----------------------------------------------------------------------------
// fbpa_checker
// Port-level checks of the block pool allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "fixed_block_pool_allocator_macros.svh"

module fbpa_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);
    // A result that is not taken stays offered.
    `FBPA_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid)
    // Only one item is in work at a time.
    `FBPA_ASSERT_NEXT(a_one, s_tvalid && s_tready, !s_tready)
    // Status never takes the unused code.
    `FBPA_ASSERT_NOW(a_status, m_tvalid, m_tdata[1:0] != 2'd3)
    // Error results carry no grant.
    `FBPA_ASSERT_NOW(a_nogrant, m_tvalid && (m_tdata[1:0] != 2'd0), m_tdata[9:2] == 8'd0)

endmodule

bind fixed_block_pool_allocator fbpa_checker u_fbpa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- tb/tb_fixed_block_pool_allocator.sv -----
// ----------------------------------------------------------------------------
// tb_fixed_block_pool_allocator
// Self-checking bench for the block pool allocator: a behavioral pool model
// predicts each result, a scoreboard compares results in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_fixed_block_pool_allocator;
    import fbpa_pkg::*;

    localparam int IDLE_LIMIT = 20000;
    localparam int NRAND      = 1400;

    // Expected result of one request.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [1:0]          pool;
        logic [5:0]          blk;
    } grant_t;

    int error_count = 0;

    // Mismatch reporting; one line per failure.
    task automatic report(input string what);
        error_count++;
        $display("ERROR @%0t: %s", $time, what);
    endtask

    // The scoreboard carries its own copy of the allocator state and the
    // queue of grants that are still to come out of the block.
    class pool_scoreboard;
        bit        mapped [NUM_POOLS];
        int        free_cnt [NUM_POOLS];
        int        head [NUM_POOLS];
        int        link [NUM_POOLS*BLOCKS_PER_POOL];
        int        order [NUM_POOLS];
        int        n_mapped;
        int        cache_p, spare_p;
        bit        cache_ok, spare_ok;
        grant_t    pending[$];

        function new();
            foreach (mapped[i]) begin
                mapped[i] = 0;
                free_cnt[i] = 0;
                head[i] = 0;
                order[i] = 0;
            end
            foreach (link[i]) link[i] = 0;
            n_mapped = 0;
            cache_p = 0;
            spare_p = 0;
            cache_ok = 0;
            spare_ok = 0;
        endfunction

        function void map_slot(int p);
            for (int i = 0; i < BLOCKS_PER_POOL; i++)
                link[p*BLOCKS_PER_POOL+i] = (i + 1 < BLOCKS_PER_POOL) ? i + 1 : 0;
            head[p] = 0;
            free_cnt[p] = BLOCKS_PER_POOL;
            mapped[p] = 1;
            for (int i = n_mapped; i > 0; i--) order[i] = order[i-1];
            order[0] = p;
            n_mapped++;
            spare_p = p; spare_ok = 1;
            cache_p = p; cache_ok = 1;
        endfunction

        function void unmap_slot(int p);
            int j;
            j = 0;
            for (int i = 0; i < n_mapped; i++)
                if (order[i] != p) begin
                    order[j] = order[i];
                    j++;
                end
            n_mapped = j;
            mapped[p] = 0;
            free_cnt[p] = 0;
            if (cache_ok && cache_p == p) cache_ok = 0;
        endfunction

        function grant_t allocate();
            grant_t g;
            int p, b;
            bit found;
            p = 0; found = 0;
            if (cache_ok) begin
                p = cache_p; found = 1;
            end else if (spare_ok) begin
                p = spare_p; found = 1;
            end else begin
                for (int i = 0; i < n_mapped && !found; i++)
                    if (free_cnt[order[i]] > 0) begin
                        p = order[i]; found = 1;
                    end
                if (!found && n_mapped < NUM_POOLS) begin
                    for (int i = 0; i < NUM_POOLS && !found; i++)
                        if (!mapped[i]) begin
                            p = i; found = 1;
                        end
                    if (found) map_slot(p);
                end
            end
            if (!found || free_cnt[p] == 0) begin
                g = '{ST_OOM, 2'd0, 6'd0};
                return g;
            end
            b = head[p] % BLOCKS_PER_POOL;
            head[p] = link[p*BLOCKS_PER_POOL+b];
            free_cnt[p]--;
            if (spare_ok && spare_p == p) spare_ok = 0;
            if (free_cnt[p] > 0) begin
                cache_p = p; cache_ok = 1;
            end else begin
                cache_p = spare_p; cache_ok = spare_ok;
            end
            g = '{ST_OK, p[1:0], b[5:0]};
            return g;
        endfunction

        function grant_t release_block(int p, int b);
            if (p >= NUM_POOLS || !mapped[p]) return '{ST_UNMAPPED, 2'd0, 6'd0};
            b = b % BLOCKS_PER_POOL;
            link[p*BLOCKS_PER_POOL+b] = head[p];
            head[p] = b;
            if (free_cnt[p] < 2*BLOCKS_PER_POOL-1) free_cnt[p]++;
            if (free_cnt[p] == BLOCKS_PER_POOL) begin
                if (spare_ok && spare_p != p) unmap_slot(p);
                else begin
                    spare_p = p; spare_ok = 1;
                    cache_p = p; cache_ok = 1;
                end
            end
            return '{ST_OK, 2'd0, 6'd0};
        endfunction

        // Note an accepted request and queue its grant.
        function void note_request(logic [S_DATA_W-1:0] d);
            if (d[0] == FUNC_ALLOC) pending.push_back(allocate());
            else pending.push_back(release_block(int'(d[2:1]), int'(d[8:3])));
        endfunction

        // Compare one result item with the oldest queued grant.
        task check_grant(logic [M_DATA_W-1:0] d);
            grant_t g;
            if (pending.size() == 0) begin
                report($sformatf("unexpected result %h", d));
                return;
            end
            g = pending.pop_front();
            if (d[1:0] !== g.status)
                report($sformatf("status %0d, expected %0d", d[1:0], g.status));
            if (d[3:2] !== g.pool)
                report($sformatf("granted_pool %0d, expected %0d", d[3:2], g.pool));
            if (d[9:4] !== g.blk)
                report($sformatf("granted_block %0d, expected %0d", d[9:4], g.blk));
        endtask
    endclass

    logic                  aclk = 0;
    logic                  aresetn = 0;
    logic                  s_tvalid = 0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 0;
    logic [M_DATA_W-1:0]   m_tdata;

    pool_scoreboard sb = new();
    bit  hold_results = 0;   // set by the stimulus to force a long stall
    bit  stim_done = 0;
    int  idle_cycles = 0;
    // Blocks currently held by the bench, so that frees are mostly legal.
    logic [7:0] held[$];

    always #10 aclk = ~aclk;

    fixed_block_pool_allocator dut (.*);

    // A free result has both granted fields zero, so an allocation of pool 0
    // block 0 looks the same; the bench then simply does not keep it.
    function automatic bit last_was_alloc(logic [M_DATA_W-1:0] d);
        return d[9:2] != 8'd0;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Scoreboard hooks and watchdog run on every edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.note_request(s_tdata);
            if (m_tvalid && m_tready) sb.check_grant(m_tdata);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                (stim_done && sb.pending.size() == 0))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Track granted blocks from the sender's view for later frees.
    always @(posedge aclk)
        if (aresetn && m_tvalid && m_tready && m_tdata[1:0] == ST_OK
            && last_was_alloc(m_tdata))
            held.push_back(m_tdata[9:2]);

    // Receiver: random stalls, plus a long hold-off when requested.
    initial begin
        int g;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_results) begin
                m_tready <= 0;
                repeat (300) @(posedge aclk);
                hold_results = 0;
            end
            g = gap_len();
            if (g > 0) begin
                m_tready <= 0;
                repeat (g) @(posedge aclk);
            end
            m_tready <= 1;
            @(posedge aclk);
        end
    end

    task automatic send(input logic f, input logic [1:0] p, input logic [5:0] b);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_tvalid <= 0;
            repeat (g) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata  <= {7'd0, b, p, f};
        @(posedge aclk iff s_tready);
    endtask

    task automatic send_alloc();
        send(FUNC_ALLOC, 2'($urandom), 6'($urandom));
    endtask

    // Free a block the bench holds, picked at random.
    task automatic send_held_free();
        int k;
        logic [7:0] pb;
        k = $urandom_range(0, held.size() - 1);
        pb = held[k];
        held.delete(k);
        send(FUNC_FREE, pb[1:0], pb[7:2]);
    endtask

    initial begin
        int r;
        repeat (11) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: frees to unmapped pools, extreme fields, first mapping,
        // filling every pool to out-of-memory is done in the random part.
        send(FUNC_FREE, 2'd0, 6'd0);
        send(FUNC_FREE, 2'd3, 6'd63);
        send(FUNC_ALLOC, 2'd3, 6'd63);
        send(FUNC_ALLOC, 2'd0, 6'd0);
        send(FUNC_FREE, 2'd0, 6'd1);
        send(FUNC_FREE, 2'd0, 6'd0);   // pool fully free: becomes the spare
        send(FUNC_ALLOC, 2'd0, 6'd0);
        send(FUNC_FREE, 2'd0, 6'd0);   // fills the pool again; the repeat below pushes past full
        send(FUNC_FREE, 2'd0, 6'd0);
        send(FUNC_FREE, 2'd1, 6'd42);
        send(FUNC_FREE, 2'd2, 6'd21);

        // Long receiver stall while requests keep coming.
        hold_results = 1;
        for (int i = 0; i < 12; i++) send_alloc();

        // Random part: phases biased to fill memory, then drain it.
        for (int n = 0; n < NRAND; n++) begin
            r = $urandom_range(0, 99);
            if ((n / 350) % 2 == 0) begin
                if (r < 80 || held.size() == 0) send_alloc();
                else if (r < 95) send_held_free();
                else send(FUNC_FREE, 2'($urandom), 6'($urandom));
            end else begin
                if (r < 75 && held.size() > 0) send_held_free();
                else if (r < 92) send_alloc();
                else send(FUNC_FREE, 2'($urandom), 6'($urandom));
            end
        end
        s_tvalid <= 0;
        stim_done = 1;

        @(posedge aclk);
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
